// ===== rtl/core/vram_scanout_pixel_converter_core_defines.svh =====
// assertion macros used by the scanout converter checker
`ifndef VRAM_SCANOUT_PIXEL_CONVERTER_CORE_DEFINES_SVH
`define VRAM_SCANOUT_PIXEL_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define VSPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define VSPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vspc_pkg.sv =====
// shared types, constants and helper functions of the scanout pixel converter
`default_nettype none

package vspc_pkg;

	// video memory limits
	localparam int VRAM_WIDTH  = 1024;
	localparam int VRAM_HEIGHT = 512;
	localparam int MAX_W = (VRAM_WIDTH < 1024) ? VRAM_WIDTH : 1024;
	localparam int MAX_H = (VRAM_HEIGHT < 512) ? VRAM_HEIGHT : 512;

	// field and state widths
	localparam int WORD_W   = 16;
	localparam int CHAN_W   = 8;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 10;
	localparam int IDX_W    = 2;
	localparam int DATA_W   = 11;
	localparam int COL_W    = $clog2(MAX_W);
	localparam int ROW_W    = $clog2(MAX_H);
	localparam int AREA_W   = $clog2(MAX_W * MAX_H + 1);
	localparam int COUNT_W  = 20;
	localparam int SCALED_W = COUNT_W + 5;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RGB24_MODE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd320;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd240;

	// pixel from the unpacker
	typedef struct packed {
		logic              emit;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_t;

	// frame position status from the tracker
	typedef struct packed {
		logic row_end;
		logic frame_last;
		logic real_content;
	} frame_status_t;

	// 5-bit colour to 8 bits by bit replication
	function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] x);
		return {x, x[4:2]};
	endfunction

	// displayed width with zero and oversize clamped
	function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] r;
		if (w == '0)
			r = WIDTH_W'(1);
		else if (w > WIDTH_W'(MAX_W))
			r = WIDTH_W'(MAX_W);
		else
			r = w;
		return r;
	endfunction

	// displayed height with zero and oversize clamped
	function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
		logic [HEIGHT_W-1:0] r;
		if (h == '0)
			r = HEIGHT_W'(1);
		else if (h > HEIGHT_W'(MAX_H))
			r = HEIGHT_W'(MAX_H);
		else
			r = h;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vram_scanout_pixel_converter_core.sv =====
// A request is held in the input register, then its pixel is registered in the result register.
// Throughput: one word per cycle while the result register is not stalled; 15-bit mode gives one pixel per word,
// 24-bit mode two pixels per three words.
// Reset (arst_n low, asynchronous): registers back to 15-bit 320x240, frame position,
// pending bytes and non-black count cleared, no pixel pending on the output.
`default_nettype none

module vram_scanout_pixel_converter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [vspc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [vspc_pkg::DATA_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vspc_pkg::WORD_W-1:0]   vram_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vspc_pkg::CHAN_W-1:0]   red,
	output logic [vspc_pkg::CHAN_W-1:0]   green,
	output logic [vspc_pkg::CHAN_W-1:0]   blue,
	output logic                          frame_last,
	output logic                          real_content
);

	logic                            rgb24_mode_q;
	logic [vspc_pkg::WIDTH_W-1:0]    frame_width_q;
	logic [vspc_pkg::HEIGHT_W-1:0]   frame_height_q;

	logic                            valid_s1;
	logic [vspc_pkg::WORD_W-1:0]     word_s1;

	logic                            out_valid_q;
	logic [vspc_pkg::CHAN_W-1:0]     red_q;
	logic [vspc_pkg::CHAN_W-1:0]     green_q;
	logic [vspc_pkg::CHAN_W-1:0]     blue_q;
	logic                            frame_last_q;
	logic                            real_content_q;

	vspc_pkg::pix_t                  pix;
	vspc_pkg::frame_status_t         status;
	logic                            advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb24_mode_q   <= 1'b0;
			frame_width_q  <= vspc_pkg::WIDTH_RESET;
			frame_height_q <= vspc_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				vspc_pkg::REG_RGB24_MODE:   rgb24_mode_q   <= cfg_data[0];
				vspc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[vspc_pkg::WIDTH_W-1:0];
				vspc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[vspc_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless its pixel finds the result register full and not drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready || !pix.emit);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			word_s1 <= vram_word;
	end

	vspc_pixel_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.word       (word_s1),
		.rgb24_mode (rgb24_mode_q),
		.advance    (advance),
		.row_end    (status.row_end),
		.pix        (pix)
	);

	vspc_frame_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.advance      (advance),
		.pix          (pix),
		.status       (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && pix.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && pix.emit) begin
			red_q          <= pix.red;
			green_q        <= pix.green;
			blue_q         <= pix.blue;
			frame_last_q   <= status.frame_last;
			real_content_q <= status.real_content;
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign frame_last   = frame_last_q;
	assign real_content = real_content_q;

endmodule

`default_nettype wire

// ===== rtl/core/vspc_pixel_unpack.sv =====
// word to pixel unpacker with the 24-bit byte stream holding register
`default_nettype none

module vspc_pixel_unpack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [vspc_pkg::WORD_W-1:0]    word,
	input  logic                           rgb24_mode,
	input  logic                           advance,
	input  logic                           row_end,
	output vspc_pkg::pix_t                 pix
);

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	logic [vspc_pkg::WORD_W-1:0] pending_bytes_q;
	logic [1:0]                  pending_count_q;
	logic [vspc_pkg::WORD_W-1:0] pending_bytes_nxt;
	logic [1:0]                  pending_count_nxt;

	// pixel assembly and next pending bytes
	always_comb begin
		pix               = '0;
		pending_bytes_nxt = '0;
		pending_count_nxt = PEND_NONE;
		if (!rgb24_mode) begin
			pix.emit  = 1'b1;
			pix.red   = vspc_pkg::widen5(word[4:0]);
			pix.green = vspc_pkg::widen5(word[9:5]);
			pix.blue  = vspc_pkg::widen5(word[14:10]);
		end else begin
			case (pending_count_q)
				PEND_ONE: begin
					pix.emit  = 1'b1;
					pix.red   = pending_bytes_q[7:0];
					pix.green = word[7:0];
					pix.blue  = word[15:8];
				end
				PEND_TWO: begin
					pix.emit          = 1'b1;
					pix.red           = pending_bytes_q[7:0];
					pix.green         = pending_bytes_q[15:8];
					pix.blue          = word[7:0];
					pending_bytes_nxt = {8'h00, word[15:8]};
					pending_count_nxt = PEND_ONE;
				end
				default: begin
					// nothing usable pending: hold the whole word
					pending_bytes_nxt = word;
					pending_count_nxt = PEND_TWO;
				end
			endcase
		end
	end

	// pending bytes, dropped at the end of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bytes_q <= '0;
			pending_count_q <= PEND_NONE;
		end else if (advance) begin
			if (pix.emit && row_end) begin
				pending_bytes_q <= '0;
				pending_count_q <= PEND_NONE;
			end else begin
				pending_bytes_q <= pending_bytes_nxt;
				pending_count_q <= pending_count_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vspc_frame_track.sv =====
// frame position tracker and non-black pixel counter
`default_nettype none

module vspc_frame_track (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [vspc_pkg::WIDTH_W-1:0]    frame_width,
	input  logic [vspc_pkg::HEIGHT_W-1:0]   frame_height,
	input  logic                            advance,
	input  vspc_pkg::pix_t                  pix,
	output vspc_pkg::frame_status_t         status
);

	logic [vspc_pkg::COL_W-1:0]    pixel_column_q;
	logic [vspc_pkg::ROW_W-1:0]    row_index_q;
	logic [vspc_pkg::COUNT_W-1:0]  nonblack_count_q;
	logic [vspc_pkg::AREA_W-1:0]   area_q;

	logic [vspc_pkg::WIDTH_W-1:0]  eff_w;
	logic [vspc_pkg::HEIGHT_W-1:0] eff_h;
	logic                          frame_end;
	logic [vspc_pkg::COUNT_W-1:0]  count_nxt;
	logic [vspc_pkg::SCALED_W-1:0] count_x20;

	assign eff_w = vspc_pkg::eff_width(frame_width);
	assign eff_h = vspc_pkg::eff_height(frame_height);

	// frame area, registered from the clamped size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			area_q <= '0;
		else
			area_q <= vspc_pkg::AREA_W'(eff_w) * vspc_pkg::AREA_W'(eff_h);
	end

	// row and frame end, a position past the end counts as the end;
	// saturating count including this pixel, count > area/20 iff 20*count > area
	always_comb begin
		status.row_end = vspc_pkg::WIDTH_W'(pixel_column_q) >= (eff_w - 1'b1);
		frame_end      = status.row_end &&
			(vspc_pkg::HEIGHT_W'(row_index_q) >= (eff_h - 1'b1));
		status.frame_last = frame_end;
		count_nxt = nonblack_count_q;
		if ((|{pix.red, pix.green, pix.blue}) && (nonblack_count_q != '1))
			count_nxt = nonblack_count_q + 1'b1;
		count_x20 = (vspc_pkg::SCALED_W'(count_nxt) << 4) +
			(vspc_pkg::SCALED_W'(count_nxt) << 2);
		status.real_content = frame_end && (count_x20 > vspc_pkg::SCALED_W'(area_q));
	end

	// position and count update per emitted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_column_q   <= '0;
			row_index_q      <= '0;
			nonblack_count_q <= '0;
		end else if (advance && pix.emit) begin
			if (status.row_end) begin
				pixel_column_q <= '0;
				if (frame_end) begin
					row_index_q      <= '0;
					nonblack_count_q <= '0;
				end else begin
					row_index_q      <= row_index_q + 1'b1;
					nonblack_count_q <= count_nxt;
				end
			end else begin
				pixel_column_q   <= pixel_column_q + 1'b1;
				nonblack_count_q <= count_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vspc_checker.sv =====
// port-level checker for the scanout pixel converter, bound to the top level
`default_nettype none

`include "vram_scanout_pixel_converter_core_defines.svh"

module vspc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [vspc_pkg::CHAN_W-1:0]   red,
	input logic [vspc_pkg::CHAN_W-1:0]   green,
	input logic [vspc_pkg::CHAN_W-1:0]   blue,
	input logic                          frame_last,
	input logic                          real_content
);

	// content flag only on the final pixel of a frame
	`VSPC_ASSERT_IMP(a_real_on_last, out_valid && real_content, frame_last, "real_content without frame_last")

	// an empty result register never blocks a new request
	`VSPC_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "in_ready low with no pixel pending")

	// a stalled pixel stays offered
	`VSPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "pixel dropped while stalled")

	// a stalled pixel keeps its value
	`VSPC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({red, green, blue, frame_last, real_content}), "pixel changed while stalled")

endmodule

bind vram_scanout_pixel_converter_core vspc_checker u_vspc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.red          (red),
	.green        (green),
	.blue         (blue),
	.frame_last   (frame_last),
	.real_content (real_content)
);

`default_nettype wire
